[src/pair_key_hash_index_macros.svh]
// Assertion macros shared by the pair key hash index RTL.
`ifndef PAIR_KEY_HASH_INDEX_MACROS_SVH
`define PAIR_KEY_HASH_INDEX_MACROS_SVH

// Condition holds in the same cycle as the trigger
`define PKH_ASSERT_SAME(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("pkh: same-cycle check failed");

// Condition holds in the cycle after the trigger
`define PKH_ASSERT_NEXT(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("pkh: next-cycle check failed");

`endif

[src/pkh_pkg.sv]
// Shared constants and types for the pair key hash index.
package pkh_pkg;

	// Table geometry
	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CAP_W       = IDX_W + 1;
	localparam int CFG_W       = 9;
	localparam int CMP_W       = (CFG_W > CAP_W) ? CFG_W : CAP_W;

	// Key and payload widths
	localparam int ID_W  = 32;
	localparam int VAL_W = 8;

	// FNV-1a 32-bit
	localparam int HASH_W = 32;
	localparam logic [HASH_W-1:0] FNV_OFFSET = 32'd2166136261;
	localparam logic [HASH_W-1:0] FNV_PRIME  = 32'd16777619;

	// Remainder unit: bits retired per cycle
	localparam int MOD_DIGIT = 4;
	localparam int MOD_STEPS = HASH_W / MOD_DIGIT;
	localparam int MOD_CNT_W = $clog2(MOD_STEPS);

	// Command codes
	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_INSERT = 1'b1;

	// One slot word in the table memory
	typedef struct packed {
		logic [ID_W-1:0]  pkg;
		logic [ID_W-1:0]  ent;
		logic [VAL_W-1:0] payload;
	} slot_t;

endpackage

[src/pair_key_hash_index.sv]
// Top level: hash index controller, slot memory and occupancy bits.
//
// One command at a time. A command is taken when start is high and busy is low; its
// result appears on hit/found_value/stored for exactly one cycle with done high, and
// the receiver cannot stall it. A command passes through the FNV-1a multiplies in
// the hash unit, then the remainder unit (four hash bits per cycle), then a linear
// probe that takes one slot at a time, in which each slot is read from
// the synchronous slot memory and checked in the following cycle. busy drops in the
// cycle done is high, so the next command can start then. With a capacity of zero the
// result comes the cycle after start and busy never rises. The occupancy bits are
// flip-flops cleared by reset, so no clearing pass is needed.
`include "pair_key_hash_index_macros.svh"

module pair_key_hash_index (
	input  logic                        clk,
	input  logic                        arst_n,
	// Configuration
	input  logic                        cfg_we,
	input  logic [pkh_pkg::CFG_W-1:0]   cfg_wdata,
	// Command
	input  logic                        start,
	output logic                        busy,
	input  logic                        cmd,
	input  logic [pkh_pkg::ID_W-1:0]    package_id,
	input  logic [pkh_pkg::ID_W-1:0]    entry_id,
	input  logic [pkh_pkg::VAL_W-1:0]   slot_value,
	// Result
	output logic                        done,
	output logic                        hit,
	output logic [pkh_pkg::VAL_W-1:0]   found_value,
	output logic                        stored
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HASH,
		ST_MOD,
		ST_READ,
		ST_CHECK
	} state_t;

	state_t                         state_q;
	logic [pkh_pkg::CFG_W-1:0]      cfg_q;
	logic [pkh_pkg::CAP_W-1:0]      cap_eff, cap_q, probes_q, idx_inc;
	logic [pkh_pkg::IDX_W-1:0]      idx_q, idx_next;
	logic                           cmd_q, occ_rd_q;
	logic [pkh_pkg::ID_W-1:0]       pkg_q, ent_q;
	logic [pkh_pkg::VAL_W-1:0]      val_q;
	logic [pkh_pkg::TABLE_DEPTH-1:0] occ_q;
	logic                           done_q, hit_q, stored_q;
	logic [pkh_pkg::VAL_W-1:0]      found_q;

	logic                           accept, hash_start, hash_valid, mod_start, mod_done;
	logic [pkh_pkg::HASH_W-1:0]     hash;
	logic [pkh_pkg::CAP_W-1:0]      mod_rem;
	logic                           key_match, ram_we, ram_re;
	pkh_pkg::slot_t                 slot_rd, slot_wr;

	// Effective capacity saturates at the table depth
	always_comb begin
		if (pkh_pkg::CMP_W'(cfg_q) > pkh_pkg::CMP_W'(pkh_pkg::TABLE_DEPTH)) begin
			cap_eff = pkh_pkg::CAP_W'(pkh_pkg::TABLE_DEPTH);
		end else begin
			cap_eff = pkh_pkg::CAP_W'(cfg_q);
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign accept     = start && !busy;
	assign hash_start = accept && (cap_eff != '0);
	assign mod_start  = (state_q == ST_HASH) && hash_valid;

	pkh_hash u_hash (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (hash_start),
		.package_id (package_id),
		.entry_id   (entry_id),
		.valid      (hash_valid),
		.hash       (hash)
	);

	pkh_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (hash),
		.divisor  (cap_q),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	// Slot memory access
	assign ram_re    = (state_q == ST_READ);
	assign key_match = (slot_rd.pkg == pkg_q) && (slot_rd.ent == ent_q);
	assign ram_we    = (state_q == ST_CHECK) && (cmd_q == pkh_pkg::CMD_INSERT) &&
	                   (!occ_rd_q || key_match);
	assign slot_wr   = '{pkg: pkg_q, ent: ent_q, payload: val_q};

	pkh_ram #(
		.DEPTH (pkh_pkg::TABLE_DEPTH),
		.WIDTH ($bits(pkh_pkg::slot_t))
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_q),
		.wdata (slot_wr),
		.re    (ram_re),
		.raddr (idx_q),
		.rdata (slot_rd)
	);

	// Linear probe step with wrap at capacity
	assign idx_inc  = pkh_pkg::CAP_W'(idx_q) + 1'b1;
	assign idx_next = (idx_inc >= cap_q) ? '0 : idx_inc[pkh_pkg::IDX_W-1:0];

	// Controller: state, probe registers and result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cfg_q    <= pkh_pkg::CFG_W'(256);
			occ_q    <= '0;
			done_q   <= 1'b0;
			hit_q    <= 1'b0;
			stored_q <= 1'b0;
			found_q  <= '0;
			cap_q    <= '0;
			probes_q <= '0;
			idx_q    <= '0;
			occ_rd_q <= 1'b0;
			cmd_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cmd_q <= cmd;
						cap_q <= cap_eff;
						if (cap_eff == '0) begin
							// Empty table: immediate miss
							done_q   <= 1'b1;
							hit_q    <= 1'b0;
							stored_q <= 1'b0;
							found_q  <= '0;
						end else begin
							state_q <= ST_HASH;
						end
					end
				end
				ST_HASH: begin
					if (hash_valid) begin
						state_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					if (mod_done) begin
						idx_q    <= mod_rem[pkh_pkg::IDX_W-1:0];
						probes_q <= '0;
						state_q  <= ST_READ;
					end
				end
				ST_READ: begin
					occ_rd_q <= occ_q[idx_q];
					state_q  <= ST_CHECK;
				end
				ST_CHECK: begin
					if (!occ_rd_q) begin
						// Empty slot ends the probe
						done_q   <= 1'b1;
						hit_q    <= 1'b0;
						found_q  <= '0;
						stored_q <= (cmd_q == pkh_pkg::CMD_INSERT);
						if (cmd_q == pkh_pkg::CMD_INSERT) begin
							occ_q[idx_q] <= 1'b1;
						end
						state_q <= ST_IDLE;
					end else if (key_match) begin
						done_q   <= 1'b1;
						hit_q    <= 1'b1;
						stored_q <= (cmd_q == pkh_pkg::CMD_INSERT);
						found_q  <= (cmd_q == pkh_pkg::CMD_INSERT) ? '0 : slot_rd.payload;
						state_q  <= ST_IDLE;
					end else if (probes_q == cap_q - 1'b1) begin
						// Every slot in range visited
						done_q   <= 1'b1;
						hit_q    <= 1'b0;
						stored_q <= 1'b0;
						found_q  <= '0;
						state_q  <= ST_IDLE;
					end else begin
						idx_q    <= idx_next;
						probes_q <= probes_q + 1'b1;
						state_q  <= ST_READ;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers of the command
	always_ff @(posedge clk) begin
		if (accept) begin
			pkg_q <= package_id;
			ent_q <= entry_id;
			val_q <= slot_value;
		end
	end

	assign done        = done_q;
	assign hit         = hit_q;
	assign found_value = found_q;
	assign stored      = stored_q;

	// A returned value only comes from a lookup hit
	`PKH_ASSERT_SAME(a_found_on_hit, clk, arst_n, done && (found_value != '0), hit && !stored)
	// Probe index stays inside the configured capacity
	`PKH_ASSERT_SAME(a_idx_in_range, clk, arst_n, state_q == ST_CHECK, pkh_pkg::CAP_W'(idx_q) < cap_q)
	// Remainder unit finishes only while the controller waits for it
	`PKH_ASSERT_SAME(a_mod_done_in_mod, clk, arst_n, mod_done, state_q == ST_MOD)
	// A started command with a nonempty table holds busy next cycle
	`PKH_ASSERT_NEXT(a_busy_after_start, clk, arst_n, hash_start, busy && !done)

endmodule

[src/pkh_ram.sv]
// Generic single-port-write, single-port-read synchronous RAM, registered read.
module pkh_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 72
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/pkh_hash.sv]
// Two-stage FNV-1a hash of the (package id, entry id) key.
module pkh_hash (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [pkh_pkg::ID_W-1:0]    package_id,
	input  logic [pkh_pkg::ID_W-1:0]    entry_id,
	output logic                        valid,
	output logic [pkh_pkg::HASH_W-1:0]  hash
);

	logic                       valid_s1, valid_s2;
	logic [pkh_pkg::HASH_W-1:0] h_s1, h_s2;
	logic [pkh_pkg::ID_W-1:0]   ent_s1;
	logic [pkh_pkg::HASH_W-1:0] mix1, mix2;

	// Mix one word per stage
	assign mix1 = (pkh_pkg::FNV_OFFSET ^ package_id) * pkh_pkg::FNV_PRIME;
	assign mix2 = (h_s1 ^ ent_s1) * pkh_pkg::FNV_PRIME;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		h_s1   <= mix1;
		ent_s1 <= entry_id;
		h_s2   <= mix2;
	end

	assign valid = valid_s2;
	assign hash  = h_s2;

endmodule

[src/pkh_mod.sv]
// Iterative remainder of the hash by the table capacity, MOD_DIGIT bits per cycle.
module pkh_mod (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [pkh_pkg::HASH_W-1:0]  dividend,
	input  logic [pkh_pkg::CAP_W-1:0]   divisor,
	output logic                        done,
	output logic [pkh_pkg::CAP_W-1:0]   rem
);

	logic                          busy_q, done_q;
	logic [pkh_pkg::MOD_CNT_W-1:0] cnt_q;
	logic [pkh_pkg::HASH_W-1:0]    num_q, num_n;
	logic [pkh_pkg::CAP_W-1:0]     div_q, rem_q, rem_n;
	logic [pkh_pkg::CAP_W:0]       trial;

	// Restoring remainder over MOD_DIGIT bits
	always_comb begin
		rem_n = rem_q;
		num_n = num_q;
		trial = '0;
		for (int i = 0; i < pkh_pkg::MOD_DIGIT; i++) begin
			trial = {rem_n, num_n[pkh_pkg::HASH_W-1]};
			num_n = num_n << 1;
			if (trial >= {1'b0, div_q}) begin
				trial = trial - {1'b0, div_q};
			end
			rem_n = trial[pkh_pkg::CAP_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= pkh_pkg::MOD_CNT_W'(pkh_pkg::MOD_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= num_n;
			rem_q <= rem_n;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

[tb/tb_top.sv]
// Self-checking testbench for pair_key_hash_index: scoreboarded lookups and inserts.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pkh_pkg::*;

	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int DRAIN_CYCLES = 600;

	typedef struct packed {
		logic [ID_W-1:0] pkg;
		logic [ID_W-1:0] ent;
	} pair_key_t;

	typedef struct packed {
		logic             op;
		pair_key_t        key;
		logic [VAL_W-1:0] val;
	} index_cmd_t;

	typedef struct packed {
		logic             hit;
		logic [VAL_W-1:0] found;
		logic             stored;
	} index_outcome_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic             start = 1'b0;
	logic             cmd = CMD_LOOKUP;
	logic [ID_W-1:0]  package_id = '0;
	logic [ID_W-1:0]  entry_id = '0;
	logic [VAL_W-1:0] slot_value = '0;
	logic             busy;
	logic             done;
	logic             hit;
	logic [VAL_W-1:0] found_value;
	logic             stored;

	// Shadow copy of the table and the capacity register
	logic [CFG_W-1:0] cap_reg = CFG_W'(256);
	logic [ID_W-1:0]  tbl_pkg [TABLE_DEPTH];
	logic [ID_W-1:0]  tbl_ent [TABLE_DEPTH];
	logic [VAL_W-1:0] tbl_val [TABLE_DEPTH];
	bit               tbl_used [TABLE_DEPTH];

	index_cmd_t     cmd_backlog[$];
	index_outcome_t outcomes_due[$];
	pair_key_t      key_pool[$];
	int             mismatch_cnt = 0;
	int             cycles = 0;
	int             gap_left = 0;
	bit             quiet = 1'b0;

	pair_key_hash_index i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.package_id  (package_id),
		.entry_id    (entry_id),
		.slot_value  (slot_value),
		.done        (done),
		.hit         (hit),
		.found_value (found_value),
		.stored      (stored)
	);

	initial forever #10 clk = ~clk;

	// FNV-1a over both ids, then linear probe of the shadow table
	function automatic index_outcome_t predict_outcome(logic op_i, logic [ID_W-1:0] pk,
			logic [ID_W-1:0] en, logic [VAL_W-1:0] v);
		index_outcome_t r;
		logic [HASH_W-1:0] h;
		logic [31:0] span;
		logic [31:0] slot;
		r = '0;
		span = (cap_reg > TABLE_DEPTH) ? TABLE_DEPTH : 32'(cap_reg);
		h = FNV_OFFSET;
		h = (h ^ pk) * FNV_PRIME;
		h = (h ^ en) * FNV_PRIME;
		if (span != 0) begin
			slot = h % span;
			for (int n = 0; n < span; n++) begin
				if (!tbl_used[slot]) begin
					if (op_i == CMD_INSERT) begin
						tbl_pkg[slot] = pk;
						tbl_ent[slot] = en;
						tbl_val[slot] = v;
						tbl_used[slot] = 1'b1;
						r.stored = 1'b1;
					end
					break;
				end
				if (tbl_pkg[slot] == pk && tbl_ent[slot] == en) begin
					r.hit = 1'b1;
					if (op_i == CMD_INSERT) begin
						tbl_val[slot] = v;
						r.stored = 1'b1;
					end else begin
						r.found = tbl_val[slot];
					end
					break;
				end
				slot = (slot + 1 >= span) ? 0 : slot + 1;
			end
		end
		return r;
	endfunction

	task automatic add_cmd(logic op_i, logic [ID_W-1:0] pk, logic [ID_W-1:0] en,
			logic [VAL_W-1:0] v);
		index_cmd_t c;
		c.op = op_i;
		c.key = '{pkg: pk, ent: en};
		c.val = v;
		cmd_backlog.push_back(c);
	endtask

	// Key pool: the two all-zero/all-one keys, random keys, some sharing one half with another
	task automatic build_pool(int pool_n);
		pair_key_t k;
		key_pool.delete();
		for (int i = 0; i < pool_n; i++) begin
			k.pkg = $urandom;
			k.ent = $urandom;
			if (i == 0) begin
				k = '0;
			end else if (i == 1) begin
				k = '1;
			end else if ($urandom_range(0, 3) == 0) begin
				k.pkg = key_pool[$urandom_range(0, i - 1)].pkg;
			end else if ($urandom_range(0, 5) == 0) begin
				k.ent = key_pool[$urandom_range(0, i - 1)].ent;
			end
			key_pool.push_back(k);
		end
	endtask

	// Mostly pool keys so inserts and lookups meet; some fresh keys as noise
	task automatic queue_random(int n, int pool_n);
		pair_key_t k;
		build_pool(pool_n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 3) == 0) begin
				k.pkg = $urandom;
				k.ent = $urandom;
			end else begin
				k = key_pool[$urandom_range(0, pool_n - 1)];
			end
			add_cmd($urandom_range(0, 1) ? CMD_INSERT : CMD_LOOKUP, k.pkg, k.ent,
				VAL_W'($urandom_range(0, 255)));
		end
	endtask

	// Block idle: nothing queued, nothing presented, nothing outstanding
	task automatic wait_idle();
		@(negedge clk);
		while (cmd_backlog.size() != 0 || outcomes_due.size() != 0 || start)
			@(negedge clk);
	endtask

	task automatic write_capacity(logic [CFG_W-1:0] v);
		wait_idle();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		cap_reg = v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Driver: one command beat at a time, random idle bursts between beats
	always @(posedge clk or negedge arst_n) begin
		index_cmd_t nxt;
		bit took;
		if (!arst_n) begin
			start <= 1'b0;
			gap_left = 0;
		end else begin
			took = start && !busy;
			if (took) begin
				outcomes_due.push_back(predict_outcome(cmd, package_id, entry_id, slot_value));
				if (!quiet && $urandom_range(0, 3) == 0)
					gap_left = $urandom_range(1, 10);
			end
			if (start && !took) begin
				// hold the beat until busy drops
			end else if (gap_left > 0) begin
				start <= 1'b0;
				gap_left--;
			end else if (cmd_backlog.size() != 0) begin
				nxt = cmd_backlog.pop_front();
				start <= 1'b1;
				cmd <= nxt.op;
				package_id <= nxt.key.pkg;
				entry_id <= nxt.key.ent;
				slot_value <= nxt.val;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: every done beat is matched against the oldest outcome
	always @(posedge clk) begin
		index_outcome_t want;
		if (arst_n && done) begin
			if (outcomes_due.size() == 0) begin
				mismatch_cnt++;
				$display("%0t: unexpected result, expected none, got hit=%0b found=%0h stored=%0b",
					$time, hit, found_value, stored);
			end else begin
				want = outcomes_due.pop_front();
				if (hit !== want.hit) begin
					mismatch_cnt++;
					$display("%0t: hit expected %0b, actual %0b", $time, want.hit, hit);
				end
				if (found_value !== want.found) begin
					mismatch_cnt++;
					$display("%0t: found_value expected %0h, actual %0h",
						$time, want.found, found_value);
				end
				if (stored !== want.stored) begin
					mismatch_cnt++;
					$display("%0t: stored expected %0b, actual %0b",
						$time, want.stored, stored);
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset capacity: empty table, extreme keys, hit, update, halves that differ
		add_cmd(CMD_LOOKUP, 32'h0, 32'h0, 8'h00);
		add_cmd(CMD_INSERT, 32'h0, 32'h0, 8'hff);
		add_cmd(CMD_LOOKUP, 32'h0, 32'h0, 8'h12);
		add_cmd(CMD_INSERT, 32'h0, 32'h0, 8'h00);
		add_cmd(CMD_LOOKUP, 32'h0, 32'h0, 8'hff);
		add_cmd(CMD_INSERT, 32'hffff_ffff, 32'hffff_ffff, 8'h5a);
		add_cmd(CMD_LOOKUP, 32'hffff_ffff, 32'hffff_ffff, 8'h00);
		add_cmd(CMD_LOOKUP, 32'hffff_ffff, 32'h0, 8'h00);
		add_cmd(CMD_LOOKUP, 32'h0, 32'hffff_ffff, 8'h00);
		add_cmd(CMD_INSERT, 32'hffff_ffff, 32'h0, 8'h80);
		add_cmd(CMD_LOOKUP, 32'hffff_ffff, 32'h0, 8'h00);
		queue_random(250, 100);

		// Zero capacity: occupied keys miss, inserts store nothing
		write_capacity(CFG_W'(0));
		add_cmd(CMD_LOOKUP, 32'h0, 32'h0, 8'h00);
		add_cmd(CMD_INSERT, 32'h1, 32'h2, 8'h33);
		add_cmd(CMD_LOOKUP, 32'h1, 32'h2, 8'h00);
		queue_random(40, 8);

		// One slot: table full after the first distinct key
		write_capacity(CFG_W'(1));
		add_cmd(CMD_INSERT, 32'h1234_5678, 32'h9abc_def0, 8'h11);
		add_cmd(CMD_INSERT, 32'h0fed_cba9, 32'h8765_4321, 8'h22);
		add_cmd(CMD_LOOKUP, 32'h0fed_cba9, 32'h8765_4321, 8'h00);
		add_cmd(CMD_LOOKUP, 32'h1234_5678, 32'h9abc_def0, 8'h00);
		queue_random(60, 4);

		// Small capacities with wrap-around and full tables
		write_capacity(CFG_W'(7));
		queue_random(120, 12);
		write_capacity(CFG_W'(2));
		queue_random(60, 5);

		// Above the depth, which saturates to the full table, then smaller capacities
		write_capacity(CFG_W'(511));
		queue_random(250, 100);
		write_capacity(CFG_W'(100));
		queue_random(150, 80);
		write_capacity(CFG_W'(37));
		queue_random(120, 50);

		// Last stretch without idling
		write_capacity(CFG_W'(300));
		wait_idle();
		quiet = 1'b1;
		queue_random(200, 100);

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0 && outcomes_due.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
